[design/bilinear_upscale_2x_defines.svh]
// assertion macros used by the checker file of the 2x bilinear upscaler
// no dependencies; included by bare file name
`ifndef BILINEAR_UPSCALE_2X_DEFINES_SVH
`define BILINEAR_UPSCALE_2X_DEFINES_SVH

// clocked assertion that also holds while reset is low
`define BU2X_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// clocked assertion that is switched off while reset is low
`define BU2X_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[design/bu2x_pkg.sv]
// shared types, constants and channel-mean functions of the 2x bilinear upscaler
// no dependencies
package bu2x_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int COORD_W    = 11;
    localparam int CFG_W      = 11;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int OUT_TDATA_W = 48;

    // red in the top byte, blue in the bottom byte
    typedef logic [PIX_W-1:0] t_pix;

    // which of the three output rows or columns a result belongs to
    typedef enum logic [1:0] {
        SEL_LO,
        SEL_MID,
        SEL_HI
    } t_sel;

    // one source pixel's worth of output values and edge flags
    typedef struct packed {
        t_pix               m4;
        t_pix               u2;
        t_pix               hz;
        t_pix               px;
        logic [COORD_W-1:0] col_base;
        logic [COORD_W-1:0] row_base;
        logic               has_top;
        logic               has_left;
        logic               has_right;
        logic               has_bot;
    } t_quad;

    function automatic t_pix mean2(input t_pix a, input t_pix b);
        t_pix          res;
        logic [CH_W:0] sum;
        res = '0;
        for (int k = 0; k < 3; k++) begin
            sum = {1'b0, a[k*CH_W +: CH_W]} + {1'b0, b[k*CH_W +: CH_W]};
            res[k*CH_W +: CH_W] = sum[CH_W:1];
        end
        return res;
    endfunction

    function automatic t_pix mean4(input t_pix a, input t_pix b, input t_pix c, input t_pix d);
        t_pix            res;
        logic [CH_W+1:0] sum;
        res = '0;
        for (int k = 0; k < 3; k++) begin
            sum = {2'b00, a[k*CH_W +: CH_W]} + {2'b00, b[k*CH_W +: CH_W]}
                + {2'b00, c[k*CH_W +: CH_W]} + {2'b00, d[k*CH_W +: CH_W]};
            res[k*CH_W +: CH_W] = sum[CH_W+1:2];
        end
        return res;
    endfunction

    function automatic t_sel sel_inc(input t_sel s);
        t_sel res;
        case (s)
            SEL_LO:  res = SEL_MID;
            default: res = SEL_HI;
        endcase
        return res;
    endfunction

endpackage

[design/bu2x_line_ram.sv]
// previous-row line store of the 2x bilinear upscaler, read-before-write
// depends on bu2x_pkg
module bu2x_line_ram (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [bu2x_pkg::ADDR_W-1:0] i_addr,
    input  bu2x_pkg::t_pix             i_wdata,
    output bu2x_pkg::t_pix             o_rdata
);

    bu2x_pkg::t_pix r_mem [bu2x_pkg::MAX_WIDTH];
    bu2x_pkg::t_pix r_rdata;

    // the read returns the entry from the previous row, then the new pixel replaces it
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/bu2x_quad_emit.sv]
// walks the output pixels of one source pixel and drives the output stream register
// depends on bu2x_pkg
module bu2x_quad_emit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bu2x_pkg::t_quad                    i_q,
    input  logic                               i_q_valid,
    output logic                               o_q_ready,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // out_column, out_row, red_out, green_out, blue_out, zero fill
    output logic [bu2x_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // last_of_run
    output logic                               o_m_tlast
);

    bu2x_pkg::t_quad r_q;
    logic            r_bv;
    bu2x_pkg::t_sel  r_rsel;
    bu2x_pkg::t_sel  r_csel;

    logic                                r_ov;
    logic [bu2x_pkg::OUT_TDATA_W-1:0]    r_out_data;
    logic                                r_out_last;

    logic                         out_free;
    logic                         emit;
    logic                         col_end;
    logic                         row_end;
    logic                         last;
    logic                         load;
    bu2x_pkg::t_pix               cur_pix;
    logic [bu2x_pkg::COORD_W-1:0] cur_col;
    logic [bu2x_pkg::COORD_W-1:0] cur_row;

    assign out_free  = !r_ov || i_m_tready;
    assign emit      = r_bv && out_free;
    assign col_end   = (r_csel == bu2x_pkg::SEL_HI)
                    || (r_csel == bu2x_pkg::SEL_MID && !r_q.has_right);
    assign row_end   = (r_rsel == bu2x_pkg::SEL_HI)
                    || (r_rsel == bu2x_pkg::SEL_MID && !r_q.has_bot);
    assign last      = col_end && row_end;
    assign o_q_ready = !r_bv || (emit && last);
    assign load      = i_q_valid && o_q_ready;

    always_comb begin
        // upper row uses the line store, the others the current row
        case (r_rsel)
            bu2x_pkg::SEL_LO: cur_pix = (r_csel == bu2x_pkg::SEL_LO) ? r_q.m4 : r_q.u2;
            default:          cur_pix = (r_csel == bu2x_pkg::SEL_LO) ? r_q.hz : r_q.px;
        endcase
        case (r_csel)
            bu2x_pkg::SEL_LO:  cur_col = r_q.col_base - bu2x_pkg::COORD_W'(1);
            bu2x_pkg::SEL_MID: cur_col = r_q.col_base;
            default:           cur_col = r_q.col_base + bu2x_pkg::COORD_W'(1);
        endcase
        case (r_rsel)
            bu2x_pkg::SEL_LO:  cur_row = r_q.row_base - bu2x_pkg::COORD_W'(1);
            bu2x_pkg::SEL_MID: cur_row = r_q.row_base;
            default:           cur_row = r_q.row_base + bu2x_pkg::COORD_W'(1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv   <= 1'b0;
            r_ov   <= 1'b0;
            r_rsel <= bu2x_pkg::SEL_MID;
            r_csel <= bu2x_pkg::SEL_MID;
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            if (load) begin
                r_bv   <= 1'b1;
                r_rsel <= i_q.has_top  ? bu2x_pkg::SEL_LO : bu2x_pkg::SEL_MID;
                r_csel <= i_q.has_left ? bu2x_pkg::SEL_LO : bu2x_pkg::SEL_MID;
            end else if (emit && last) begin
                r_bv <= 1'b0;
            end else if (emit) begin
                if (col_end) begin
                    r_csel <= r_q.has_left ? bu2x_pkg::SEL_LO : bu2x_pkg::SEL_MID;
                    r_rsel <= bu2x_pkg::sel_inc(r_rsel);
                end else begin
                    r_csel <= bu2x_pkg::sel_inc(r_csel);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_q <= i_q;
        end
        if (emit) begin
            r_out_data <= {2'b00,
                           cur_pix[bu2x_pkg::CH_W-1:0],
                           cur_pix[2*bu2x_pkg::CH_W-1:bu2x_pkg::CH_W],
                           cur_pix[3*bu2x_pkg::CH_W-1:2*bu2x_pkg::CH_W],
                           cur_row, cur_col};
            r_out_last <= last;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

[design/bilinear_upscale_2x.sv]
// Bilinear 2x upscaler: takes RGB source pixels in raster order and streams the
// doubled image as coordinate-tagged pixels, one output transfer per cycle while
// neither stream stalls. A source pixel in the interior yields four output pixels;
// pixels on the first row or column yield fewer (down to one for the top-left
// pixel) and pixels on the last row or column more (up to nine for the bottom-right
// pixel), all sent out one at a time through the single output register. The first
// output pixel passes the input register, the emitter's quad register and the output
// register. Width and height are clamped to 2..1024; any register write restarts the
// frame at source pixel (0, 0). The line store needs no clearing after reset.
// depends on bu2x_pkg, bu2x_line_ram and bu2x_quad_emit
module bilinear_upscale_2x (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [bu2x_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // red_in, green_in, blue_in
    input  logic [bu2x_pkg::PIX_W-1:0]        i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // out_column, out_row, red_out, green_out, blue_out, zero fill
    output logic [bu2x_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // last_of_run
    output logic                              o_m_tlast
);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;
    localparam logic [bu2x_pkg::CFG_W-1:0] MAX_W_CFG = bu2x_pkg::CFG_W'(bu2x_pkg::MAX_WIDTH);
    localparam logic [bu2x_pkg::CFG_W-1:0] MAX_H_CFG = bu2x_pkg::CFG_W'(bu2x_pkg::MAX_HEIGHT);
    localparam logic [bu2x_pkg::CFG_W-1:0] MIN_CFG   = bu2x_pkg::CFG_W'(2);

    // clamped size minus one
    logic [bu2x_pkg::ADDR_W-1:0] r_wlast;
    logic [bu2x_pkg::ROW_W-1:0]  r_hlast;
    logic [bu2x_pkg::ADDR_W-1:0] r_col;
    logic [bu2x_pkg::ROW_W-1:0]  r_row;

    logic                        r_av;
    bu2x_pkg::t_pix              r_a_pix;
    logic [bu2x_pkg::ADDR_W-1:0] r_a_col;
    logic [bu2x_pkg::ROW_W-1:0]  r_a_row;
    logic                        r_a_right;
    logic                        r_a_bot;
    bu2x_pkg::t_pix              r_lf;
    bu2x_pkg::t_pix              r_ul;

    logic                        s_acc;
    logic                        a_move;
    logic                        q_ready;
    logic                        at_right;
    logic                        at_bot;
    bu2x_pkg::t_pix              in_pix;
    bu2x_pkg::t_pix              up_pix;
    bu2x_pkg::t_quad             quad;
    logic [bu2x_pkg::CFG_W-1:0]  cfg_m1;
    logic [bu2x_pkg::ADDR_W-1:0] n_wlast;
    logic [bu2x_pkg::ROW_W-1:0]  n_hlast;

    assign in_pix   = {i_s_tdata[7:0], i_s_tdata[15:8], i_s_tdata[23:16]};
    assign a_move   = r_av && q_ready;
    assign o_s_tready = !r_av || a_move;
    assign s_acc    = i_s_tvalid && o_s_tready;
    assign at_right = (r_col == r_wlast);
    assign at_bot   = (r_row == r_hlast);

    always_comb begin
        cfg_m1 = i_cfg_data - bu2x_pkg::CFG_W'(1);
        if (i_cfg_data < MIN_CFG) begin
            n_wlast = bu2x_pkg::ADDR_W'(1);
        end else if (i_cfg_data > MAX_W_CFG) begin
            n_wlast = bu2x_pkg::ADDR_W'(bu2x_pkg::MAX_WIDTH - 1);
        end else begin
            n_wlast = cfg_m1[bu2x_pkg::ADDR_W-1:0];
        end
        if (i_cfg_data < MIN_CFG) begin
            n_hlast = bu2x_pkg::ROW_W'(1);
        end else if (i_cfg_data > MAX_H_CFG) begin
            n_hlast = bu2x_pkg::ROW_W'(bu2x_pkg::MAX_HEIGHT - 1);
        end else begin
            n_hlast = cfg_m1[bu2x_pkg::ROW_W-1:0];
        end
    end

    bu2x_line_ram u_line_ram (
        .i_clk   (i_clk),
        .i_en    (s_acc),
        .i_addr  (r_col),
        .i_wdata (in_pix),
        .o_rdata (up_pix)
    );

    always_comb begin
        quad.m4        = bu2x_pkg::mean4(r_ul, up_pix, r_lf, r_a_pix);
        quad.u2        = bu2x_pkg::mean2(up_pix, r_a_pix);
        quad.hz        = bu2x_pkg::mean2(r_lf, r_a_pix);
        quad.px        = r_a_pix;
        quad.col_base  = bu2x_pkg::COORD_W'({r_a_col, 1'b0});
        quad.row_base  = bu2x_pkg::COORD_W'({r_a_row, 1'b0});
        quad.has_top   = (r_a_row != '0);
        quad.has_left  = (r_a_col != '0);
        quad.has_right = r_a_right;
        quad.has_bot   = r_a_bot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= bu2x_pkg::ADDR_W'(639);
            r_hlast <= bu2x_pkg::ROW_W'(479);
            r_col   <= '0;
            r_row   <= '0;
            r_av    <= 1'b0;
            r_lf    <= '0;
            r_ul    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDTH:  r_wlast <= n_wlast;
                    REG_HEIGHT: r_hlast <= n_hlast;
                    default:    r_wlast <= r_wlast;
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (s_acc) begin
                if (at_right) begin
                    r_col <= '0;
                    r_row <= at_bot ? '0 : r_row + bu2x_pkg::ROW_W'(1);
                end else begin
                    r_col <= r_col + bu2x_pkg::ADDR_W'(1);
                end
            end
            if (s_acc) begin
                r_av <= 1'b1;
            end else if (a_move) begin
                r_av <= 1'b0;
            end
            // neighbours of the next source pixel
            if (a_move) begin
                r_lf <= r_a_pix;
                r_ul <= up_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_a_pix   <= in_pix;
            r_a_col   <= r_col;
            r_a_row   <= r_row;
            r_a_right <= at_right;
            r_a_bot   <= at_bot;
        end
    end

    bu2x_quad_emit u_quad_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q        (quad),
        .i_q_valid  (r_av),
        .o_q_ready  (q_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

[design/bu2x_checker.sv]
// port-level checks of the 2x bilinear upscaler, bound to the top level
// depends on bu2x_pkg and bilinear_upscale_2x_defines.svh
`include "bilinear_upscale_2x_defines.svh"

module bu2x_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [bu2x_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input logic                              o_m_tlast
);

    logic                         out_xfer;
    logic [bu2x_pkg::COORD_W-1:0] out_row;

    assign out_xfer = o_m_tvalid && i_m_tready;
    assign out_row  = o_m_tdata[2*bu2x_pkg::COORD_W-1:bu2x_pkg::COORD_W];

    `BU2X_ASSERT(a_rst_no_out, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid right after reset")

    `BU2X_ASSERT(a_rst_ready, i_clk, !i_rst_n |=> o_s_tready, "input not ready after reset")

    `BU2X_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "stalled output changed")

    // within a run the row steps by zero or one
    `BU2X_ASSERT_RST(a_run_rows, i_clk, i_rst_n, (out_xfer && !o_m_tlast) ##1 out_xfer |-> (out_row == $past(out_row)) || (out_row == $past(out_row) + bu2x_pkg::COORD_W'(1)), "row jump inside a run")

endmodule

bind bilinear_upscale_2x bu2x_checker u_checker (.*);

[tb/bilinear_upscale_2x_tb.sv]
// self-checking testbench of bilinear_upscale_2x: streams RGB source pixels through several
// frame sizes with random gaps on both stream sides and compares every output transfer
// depends on bu2x_pkg and the bilinear_upscale_2x RTL
module bilinear_upscale_2x_tb;

    localparam int CW          = bu2x_pkg::COORD_W;
    localparam int CHW         = bu2x_pkg::CH_W;
    localparam int CFGW        = bu2x_pkg::CFG_W;
    localparam int PXW         = bu2x_pkg::PIX_W;
    localparam int ODW         = bu2x_pkg::OUT_TDATA_W;
    localparam int MAXW        = bu2x_pkg::MAX_WIDTH;
    localparam int MAXH        = bu2x_pkg::MAX_HEIGHT;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int NUM_PIXELS  = 420;
    localparam int TAIL_CYCLES = 20;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CHW-1:0] red;
        logic [CHW-1:0] green;
        logic [CHW-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [CW-1:0] col;
        logic [CW-1:0] row;
        rgb_t          pix;
        logic          last;
    } out_px_t;

    typedef struct {
        logic            is_cfg;
        logic            cfg_idx;
        logic [CFGW-1:0] cfg_val;
        rgb_t            pix;
        logic            typed;
        out_px_t         want;
    } stim_row_t;

    logic            i_clk      = 1'b0;
    logic            i_rst_n    = 1'b0;
    logic            i_cfg_we   = 1'b0;
    logic            i_cfg_idx  = 1'b0;
    logic [CFGW-1:0] i_cfg_data = '0;
    logic            i_s_tvalid = 1'b0;
    logic            o_s_tready;
    // red_in, green_in, blue_in
    logic [PXW-1:0]  i_s_tdata  = '0;
    logic            o_m_tvalid;
    logic            i_m_tready = 1'b0;
    // out_column, out_row, red_out, green_out, blue_out, zero fill
    logic [ODW-1:0]  o_m_tdata;
    // last_of_run
    logic            o_m_tlast;

    bilinear_upscale_2x u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    rgb_t            line_store [MAXW];
    rgb_t            left_px    = '0;
    rgb_t            upleft_px  = '0;
    int unsigned     col_cnt    = 0;
    int unsigned     row_cnt    = 0;
    logic [CFGW-1:0] width_reg  = CFGW'(640);
    logic [CFGW-1:0] height_reg = CFGW'(480);

    out_px_t     run_q[$];
    out_px_t     pending_px_q[$];
    stim_row_t   stim_rows[$];
    logic        tx_calm   = 1'b0;
    int unsigned n_in      = 0;
    int unsigned n_out     = 0;
    int unsigned n_cfg     = 0;
    int unsigned n_fail    = 0;
    int unsigned cycle_cnt = 0;

    function automatic rgb_t avg_two(input rgb_t a, input rgb_t b);
        rgb_t m;
        m.red   = CHW'((int'(a.red) + int'(b.red)) >> 1);
        m.green = CHW'((int'(a.green) + int'(b.green)) >> 1);
        m.blue  = CHW'((int'(a.blue) + int'(b.blue)) >> 1);
        return m;
    endfunction

    function automatic rgb_t avg_four(input rgb_t a, input rgb_t b, input rgb_t c,
                                      input rgb_t d);
        rgb_t m;
        m.red   = CHW'((int'(a.red) + int'(b.red) + int'(c.red) + int'(d.red)) >> 2);
        m.green = CHW'((int'(a.green) + int'(b.green) + int'(c.green) + int'(d.green)) >> 2);
        m.blue  = CHW'((int'(a.blue) + int'(b.blue) + int'(c.blue) + int'(d.blue)) >> 2);
        return m;
    endfunction

    function automatic int unsigned clamp_dim(input logic [CFGW-1:0] v, input int unsigned hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void put_out(input int unsigned x, input int unsigned y, input rgb_t v);
        out_px_t o;
        o.col  = CW'(x);
        o.row  = CW'(y);
        o.pix  = v;
        o.last = 1'b0;
        run_q.push_back(o);
    endfunction

    // output pixels of one output row completed by source column c
    function automatic void emit_row(input int unsigned c, input int unsigned w,
                                     input int unsigned y, input rgb_t lv, input rgb_t rv);
        if (c > 0) put_out(2 * c - 1, y, lv);
        put_out(2 * c, y, rv);
        if (c == w - 1) put_out(2 * c + 1, y, rv);
    endfunction

    // fills run_q with the output pixels one source pixel completes
    function automatic void upscale_source_pixel(input rgb_t p);
        int unsigned w, h, c, r;
        rgb_t        up, ul, lf, hz;
        out_px_t     tail;
        w  = clamp_dim(width_reg, MAXW);
        h  = clamp_dim(height_reg, MAXH);
        c  = col_cnt;
        r  = row_cnt;
        if (c >= w) c = 0;
        if (r >= h) r = 0;
        up = line_store[c];
        ul = upleft_px;
        lf = left_px;
        hz = avg_two(lf, p);
        run_q.delete();
        if (r > 0) emit_row(c, w, 2 * r - 1, avg_four(ul, up, lf, p), avg_two(up, p));
        emit_row(c, w, 2 * r, hz, p);
        // bottom edge repeats the row above
        if (r == h - 1) emit_row(c, w, 2 * r + 1, hz, p);
        tail = run_q.pop_back();
        tail.last = 1'b1;
        run_q.push_back(tail);
        upleft_px     = up;
        line_store[c] = p;
        left_px       = p;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_cnt = c;
        row_cnt = r;
    endfunction

    function automatic void check_out_pixel(input logic [ODW-1:0] d, input logic lst);
        out_px_t got, want;
        got.col       = d[CW-1:0];
        got.row       = d[2*CW-1:CW];
        got.pix.red   = d[2*CW +: CHW];
        got.pix.green = d[2*CW+CHW +: CHW];
        got.pix.blue  = d[2*CW+2*CHW +: CHW];
        got.last      = lst;
        if (pending_px_q.size() == 0) begin
            $error("unexpected output transfer: col %0d row %0d", got.col, got.row);
            n_fail++;
            return;
        end
        want = pending_px_q.pop_front();
        if (got.col !== want.col) begin
            $error("out_column: expected %0d, got %0d", want.col, got.col);
            n_fail++;
        end
        if (got.row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, got.row);
            n_fail++;
        end
        if (got.pix.red !== want.pix.red) begin
            $error("red_out: expected %0d, got %0d", want.pix.red, got.pix.red);
            n_fail++;
        end
        if (got.pix.green !== want.pix.green) begin
            $error("green_out: expected %0d, got %0d", want.pix.green, got.pix.green);
            n_fail++;
        end
        if (got.pix.blue !== want.pix.blue) begin
            $error("blue_out: expected %0d, got %0d", want.pix.blue, got.pix.blue);
            n_fail++;
        end
        if (got.last !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, got.last);
            n_fail++;
        end
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CHW-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            default: return CHW'($urandom);
        endcase
    endfunction

    function automatic stim_row_t cfg_row(input logic idx, input int unsigned val);
        stim_row_t s;
        s         = '{default: '0};
        s.is_cfg  = 1'b1;
        s.cfg_idx = idx;
        s.cfg_val = CFGW'(val);
        return s;
    endfunction

    function automatic stim_row_t px_row(input logic [CHW-1:0] r, input logic [CHW-1:0] g,
                                         input logic [CHW-1:0] b);
        stim_row_t s;
        s     = '{default: '0};
        s.pix = '{red: r, green: g, blue: b};
        return s;
    endfunction

    // first pixel of a frame: a single copy at the origin
    function automatic stim_row_t origin_row(input logic [CHW-1:0] r, input logic [CHW-1:0] g,
                                             input logic [CHW-1:0] b);
        stim_row_t s;
        s           = px_row(r, g, b);
        s.typed     = 1'b1;
        s.want.col  = '0;
        s.want.row  = '0;
        s.want.pix  = s.pix;
        s.want.last = 1'b1;
        return s;
    endfunction

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_px_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFGW-1:0] val);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_WIDTH) width_reg = val;
        else height_reg = val;
        col_cnt = 0;
        row_cnt = 0;
        n_cfg++;
    endtask

    task automatic send_pixel(input rgb_t p, input logic typed, input out_px_t want);
        int unsigned gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {p.blue, p.green, p.red};
        do @(posedge i_clk); while (!o_s_tready);
        upscale_source_pixel(p);
        if (typed) pending_px_q.push_back(want);
        else foreach (run_q[k]) pending_px_q.push_back(run_q[k]);
        n_in++;
        gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : pick_len();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // output side: random stalls plus a long hold-off to back the block up
    initial begin : rx_side
        int unsigned stall_left;
        logic        rx_calm;
        stall_left = 0;
        rx_calm    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                check_out_pixel(o_m_tdata, o_m_tlast);
                n_out++;
                if (n_out == 300 || n_out == 1200) stall_left = 500;
                if (n_out % 128 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            end
            if (stall_left != 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
                stall_left = pick_len() - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("bilinear_upscale_2x verification failed");
        $finish;
    end

    initial begin : tx_side
        int unsigned     kind, sel, frame, n;
        logic [CFGW-1:0] new_w, new_h;
        rgb_t            rp;

        // defaults after reset, frame restart on a write, clamping, wrap at end of frame
        stim_rows.push_back(origin_row(8'hff, 8'h00, 8'h80));
        stim_rows.push_back(px_row(8'h00, 8'hff, 8'h7f));
        stim_rows.push_back(px_row(8'hff, 8'hff, 8'hff));
        stim_rows.push_back(px_row(8'h00, 8'h00, 8'h00));
        stim_rows.push_back(cfg_row(REG_WIDTH, 0));
        stim_rows.push_back(cfg_row(REG_HEIGHT, 1));
        stim_rows.push_back(origin_row(8'h00, 8'h00, 8'h00));
        stim_rows.push_back(px_row(8'hff, 8'hff, 8'hff));
        stim_rows.push_back(px_row(8'h80, 8'h40, 8'h20));
        stim_rows.push_back(px_row(8'h01, 8'hfe, 8'h7f));
        stim_rows.push_back(origin_row(8'h55, 8'haa, 8'h0f));
        stim_rows.push_back(px_row(8'haa, 8'h55, 8'hf0));
        stim_rows.push_back(px_row(8'hfe, 8'h01, 8'hff));
        stim_rows.push_back(cfg_row(REG_WIDTH, 2047));
        stim_rows.push_back(cfg_row(REG_HEIGHT, 1025));
        stim_rows.push_back(origin_row(8'h12, 8'h34, 8'h56));
        stim_rows.push_back(px_row(8'hff, 8'hff, 8'hff));
        stim_rows.push_back(px_row(8'h00, 8'h00, 8'h00));
        stim_rows.push_back(cfg_row(REG_WIDTH, 3));
        stim_rows.push_back(cfg_row(REG_HEIGHT, 3));
        stim_rows.push_back(origin_row(8'hff, 8'hff, 8'hff));
        stim_rows.push_back(px_row(8'hff, 8'hff, 8'hff));
        stim_rows.push_back(px_row(8'hff, 8'h00, 8'hff));
        stim_rows.push_back(px_row(8'hff, 8'hff, 8'hff));
        stim_rows.push_back(px_row(8'hff, 8'hff, 8'hff));
        stim_rows.push_back(px_row(8'h03, 8'h01, 8'hfe));
        stim_rows.push_back(px_row(8'h00, 8'hff, 8'h00));
        stim_rows.push_back(px_row(8'hff, 8'hfd, 8'h01));
        stim_rows.push_back(px_row(8'h7f, 8'h80, 8'h00));
        stim_rows.push_back(origin_row(8'h01, 8'h02, 8'h03));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            if (stim_rows[k].is_cfg) write_reg(stim_rows[k].cfg_idx, stim_rows[k].cfg_val);
            else send_pixel(stim_rows[k].pix, stim_rows[k].typed, stim_rows[k].want);
        end

        while (n_in < NUM_PIXELS) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    new_w = CFGW'(2);
                    new_h = CFGW'(2);
                end
                1: begin
                    new_w = CFGW'($urandom_range(0, 1));
                    new_h = CFGW'($urandom_range(0, 1));
                end
                2: begin
                    new_w = ($urandom_range(0, 1) != 0) ? CFGW'(MAXW)
                                                        : CFGW'($urandom_range(MAXW, 2047));
                    new_h = CFGW'($urandom_range(0, 2047));
                end
                3: begin
                    new_w = CFGW'($urandom_range(2, 6));
                    new_h = CFGW'($urandom_range(MAXH, 2047));
                end
                default: begin
                    new_w = CFGW'($urandom_range(2, 9));
                    new_h = CFGW'($urandom_range(2, 6));
                end
            endcase
            sel = $urandom_range(0, 5);
            if (sel != 1) write_reg(REG_WIDTH, new_w);
            if (sel != 0) write_reg(REG_HEIGHT, new_h);
            tx_calm = ($urandom_range(0, 3) == 0);
            frame = clamp_dim(width_reg, MAXW) * clamp_dim(height_reg, MAXH);
            // big frames are only started, small ones run at least to the wrap and mostly past it
            if (frame > 200) n = $urandom_range(8, 30);
            else n = frame * $urandom_range(1, 2) + $urandom_range(0, frame - 1);
            repeat (n) begin
                rp.red   = rand_chan();
                rp.green = rand_chan();
                rp.blue  = rand_chan();
                send_pixel(rp, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run: %0d source pixels, %0d output transfers, %0d register writes",
                 n_in, n_out, n_cfg);
        $display("frame sizes from clamped extremes to small frames run past their wrap");
        if (n_fail == 0) begin
            $display("bilinear_upscale_2x verification clean");
        end else begin
            $display("bilinear_upscale_2x verification failed");
        end
        $finish;
    end

endmodule

[bilinear_upscale_2x.f]
+incdir+design
design/bu2x_pkg.sv
design/bu2x_line_ram.sv
design/bu2x_quad_emit.sv
design/bilinear_upscale_2x.sv
design/bu2x_checker.sv
tb/bilinear_upscale_2x_tb.sv
